// ===== hw/rtl/fas_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, op codes and types of the frame animation sequencer
package fas_pkg;

	// table size and time width
	localparam int MAX_FRAMES = 64;
	localparam int TIME_W     = 32;

	// field widths of the request and result channels
	localparam int OP_W    = 3;
	localparam int FRAME_W = 6;

	// derived widths
	localparam int IDX_W     = $clog2(MAX_FRAMES);
	localparam int COUNT_W   = $clog2(MAX_FRAMES + 1);
	localparam int ACC_W     = TIME_W + IDX_W;
	localparam int SUM_W     = ACC_W + 1;
	localparam int BIT_CNT_W = $clog2(SUM_W);
	localparam int SEL_W     = (COUNT_W > FRAME_W) ? COUNT_W : FRAME_W;

	// request op codes
	localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD_FRAME  = 3'd1;
	localparam logic [OP_W-1:0] OP_SET_FRAME  = 3'd2;
	localparam logic [OP_W-1:0] OP_SET_PAUSED = 3'd3;
	localparam logic [OP_W-1:0] OP_SET_DONE   = 3'd4;

	// result of the shared subtract and compare unit
	typedef struct packed {
		logic [SUM_W-1:0] diff;
		logic             borrow;
	} sub_res_t;

endpackage

// ===== hw/rtl/fas_if.sv =====
`timescale 1ns / 1ps
// request, result and configuration channel interfaces
interface fas_item_if;
	logic                       valid;
	logic                       ready;
	logic [fas_pkg::OP_W-1:0]    op;
	logic [fas_pkg::TIME_W-1:0]  time_step;
	logic [fas_pkg::TIME_W-1:0]  frame_time;
	logic [fas_pkg::FRAME_W-1:0] frame_select;
	logic                       restart;
	logic                       flag_value;

	modport source (
		output valid, op, time_step, frame_time, frame_select, restart, flag_value,
		input  ready
	);
	modport sink (
		input  valid, op, time_step, frame_time, frame_select, restart, flag_value,
		output ready
	);
endinterface

interface fas_result_if;
	logic                       valid;
	logic                       ready;
	logic [fas_pkg::FRAME_W-1:0] frame_index;
	logic                       finished;
	logic                       halted;
	logic                       table_full;

	modport source (
		output valid, frame_index, finished, halted, table_full,
		input  ready
	);
	modport sink (
		input  valid, frame_index, finished, halted, table_full,
		output ready
	);
endinterface

interface fas_cfg_if;
	logic valid;
	logic ready;
	logic loop_enable;

	modport source (
		output valid, loop_enable,
		input  ready
	);
	modport sink (
		input  valid, loop_enable,
		output ready
	);
endinterface

// ===== hw/rtl/fas_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
module fas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/fas_subcmp.sv =====
`timescale 1ns / 1ps
// shared subtract and compare unit used by the modulo and frame stepping loops
module fas_subcmp (
	input  logic [fas_pkg::SUM_W-1:0] a,
	input  logic [fas_pkg::SUM_W-1:0] b,
	output fas_pkg::sub_res_t         res
);

	logic [fas_pkg::SUM_W:0] full_diff;

	// one wide subtract, borrow flags a below b
	always_comb begin
		full_diff  = {1'b0, a} - {1'b0, b};
		res.diff   = full_diff[fas_pkg::SUM_W-1:0];
		res.borrow = full_diff[fas_pkg::SUM_W];
	end

endmodule

// ===== hw/rtl/frame_animation_sequencer.sv =====
`timescale 1ns / 1ps
// top level: frame animation sequencer with its control sequencer
// Add, set and flag requests go from acceptance straight to S_FINISH, which loads the result.
// A tick with frames loaded and neither paused nor done runs SUM_W (39) remainder steps on the
// shared subtractor, then c table reads and compares (1 to MAX_FRAMES); other ticks go
// straight to S_FINISH. One request at a time: ready drops on acceptance and returns with the result.
// Reset (arst_n low) clears frame count, total, elapsed time, frame index, flags, result
// valid and loop_enable at once; the duration table holds no reset value.
module frame_animation_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	fas_item_if.sink           item,
	fas_result_if.source       result,
	fas_cfg_if.sink            cfg
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MOD    = 3'd1;
	localparam logic [2:0] S_FETCH  = 3'd2;
	localparam logic [2:0] S_STEP   = 3'd3;
	localparam logic [2:0] S_FINISH = 3'd4;

	logic [2:0]                       state_q;
	logic                             loop_q;
	logic [fas_pkg::COUNT_W-1:0]      loaded_q;
	logic [fas_pkg::ACC_W-1:0]        total_q;
	logic [fas_pkg::ACC_W-1:0]        elapsed_q;
	logic [fas_pkg::IDX_W-1:0]        cur_q;
	logic                             paused_q;
	logic                             done_q;
	logic                             full_q;
	logic [fas_pkg::SUM_W-1:0]        sum_q;
	logic [fas_pkg::BIT_CNT_W-1:0]    bit_cnt_q;
	logic [fas_pkg::COUNT_W-1:0]      guard_q;
	logic                             res_valid_q;
	logic [fas_pkg::FRAME_W-1:0]      res_frame_q;
	logic                             res_finished_q;
	logic                             res_halted_q;
	logic                             res_full_q;

	logic                             accept;
	logic [fas_pkg::COUNT_W-1:0]      last_frame;
	logic                             table_is_full;
	logic                             ram_we;
	logic [fas_pkg::TIME_W-1:0]       ram_rdata;
	logic [fas_pkg::SUM_W-1:0]        unit_a;
	logic [fas_pkg::SUM_W-1:0]        unit_b;
	fas_pkg::sub_res_t                unit_res;
	logic [fas_pkg::ACC_W-1:0]        rem_next;
	logic                             at_last;
	logic                             guard_end;

	// handshake and derived control
	assign item.ready    = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;
	assign accept        = item.valid && item.ready;
	assign last_frame    = (loaded_q == '0) ? '0 : loaded_q - fas_pkg::COUNT_W'(1);
	assign table_is_full = (loaded_q >= fas_pkg::COUNT_W'(fas_pkg::MAX_FRAMES));
	assign ram_we        = accept && (item.op == fas_pkg::OP_ADD_FRAME) && !table_is_full
		&& (item.frame_time != '0);
	assign at_last       = (fas_pkg::COUNT_W'(cur_q) == last_frame);
	assign guard_end     = ((guard_q + fas_pkg::COUNT_W'(1)) == loaded_q);

	// duration table
	fas_ram #(
		.WIDTH(fas_pkg::TIME_W),
		.DEPTH(fas_pkg::MAX_FRAMES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (loaded_q[fas_pkg::IDX_W-1:0]),
		.wdata (item.frame_time),
		.re    (state_q == S_FETCH),
		.raddr (cur_q),
		.rdata (ram_rdata)
	);

	// operand select for the shared unit
	always_comb begin
		if (state_q == S_MOD) begin
			unit_a = {elapsed_q, sum_q[fas_pkg::SUM_W-1]};
			unit_b = {1'b0, total_q};
		end else begin
			unit_a = {1'b0, elapsed_q};
			unit_b = {{(fas_pkg::SUM_W-fas_pkg::TIME_W){1'b0}}, ram_rdata};
		end
	end

	fas_subcmp u_subcmp (
		.a   (unit_a),
		.b   (unit_b),
		.res (unit_res)
	);

	// restoring remainder step
	assign rem_next = unit_res.borrow ? unit_a[fas_pkg::ACC_W-1:0]
		: unit_res.diff[fas_pkg::ACC_W-1:0];

	// loop enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			loop_q <= cfg.loop_enable;
		end
	end

	// sequencer and animation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			loaded_q  <= '0;
			total_q   <= '0;
			elapsed_q <= '0;
			cur_q     <= '0;
			paused_q  <= 1'b0;
			done_q    <= 1'b0;
			full_q    <= 1'b0;
			bit_cnt_q <= '0;
			guard_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						full_q  <= 1'b0;
						state_q <= S_FINISH;
						unique case (item.op)
							fas_pkg::OP_TICK: begin
								if (!paused_q && !done_q && (loaded_q != '0)) begin
									elapsed_q <= '0;
									bit_cnt_q <= fas_pkg::BIT_CNT_W'(fas_pkg::SUM_W - 1);
									state_q   <= S_MOD;
								end
							end
							fas_pkg::OP_ADD_FRAME: begin
								if (table_is_full) begin
									full_q <= 1'b1;
								end else if (item.frame_time != '0) begin
									loaded_q <= loaded_q + fas_pkg::COUNT_W'(1);
									total_q  <= total_q + fas_pkg::ACC_W'(item.frame_time);
								end
							end
							fas_pkg::OP_SET_FRAME: begin
								if (fas_pkg::SEL_W'(item.frame_select) < fas_pkg::SEL_W'(last_frame)) begin
									cur_q <= fas_pkg::IDX_W'(item.frame_select);
								end else begin
									cur_q <= fas_pkg::IDX_W'(last_frame);
								end
								if (item.restart) begin
									paused_q  <= 1'b0;
									done_q    <= 1'b0;
									elapsed_q <= '0;
								end
							end
							fas_pkg::OP_SET_PAUSED: begin
								paused_q <= item.flag_value;
							end
							fas_pkg::OP_SET_DONE: begin
								cur_q  <= fas_pkg::IDX_W'(last_frame);
								done_q <= item.flag_value;
							end
							default: begin
							end
						endcase
					end
				end
				S_MOD: begin
					// elapsed_q holds the running remainder here
					elapsed_q <= rem_next;
					if (bit_cnt_q == '0) begin
						guard_q <= '0;
						state_q <= S_FETCH;
					end else begin
						bit_cnt_q <= bit_cnt_q - fas_pkg::BIT_CNT_W'(1);
					end
				end
				S_FETCH: begin
					state_q <= S_STEP;
				end
				S_STEP: begin
					if (unit_res.borrow) begin
						state_q <= S_FINISH;
					end else begin
						elapsed_q <= unit_res.diff[fas_pkg::ACC_W-1:0];
						guard_q   <= guard_q + fas_pkg::COUNT_W'(1);
						if (at_last && !loop_q) begin
							done_q  <= 1'b1;
							state_q <= S_FINISH;
						end else begin
							cur_q   <= at_last ? '0 : cur_q + fas_pkg::IDX_W'(1);
							state_q <= guard_end ? S_FINISH : S_FETCH;
						end
					end
				end
				S_FINISH: begin
					if (!res_valid_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// dividend shift register for the remainder loop
	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q <= fas_pkg::SUM_W'(elapsed_q) + fas_pkg::SUM_W'(item.time_step);
		end else if (state_q == S_MOD) begin
			sum_q <= sum_q << 1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == S_FINISH) && (!res_valid_q || result.ready)) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FINISH) && (!res_valid_q || result.ready)) begin
			res_frame_q    <= fas_pkg::FRAME_W'(cur_q);
			res_finished_q <= done_q;
			res_halted_q   <= paused_q;
			res_full_q     <= full_q;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.frame_index = res_frame_q;
	assign result.finished    = res_finished_q;
	assign result.halted      = res_halted_q;
	assign result.table_full  = res_full_q;

`ifndef SYNTHESIS
	// elapsed time stays below the loaded total between requests
	a_elapsed_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && loaded_q != '0) |-> (elapsed_q < total_q))
		else $error("elapsed time not below total");

	// frame index stays inside the loaded frames
	a_cur_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(loaded_q != '0) |-> (fas_pkg::COUNT_W'(cur_q) < loaded_q))
		else $error("frame index beyond loaded frames");

	// frame count never exceeds the table
	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= fas_pkg::COUNT_W'(fas_pkg::MAX_FRAMES))
		else $error("frame count beyond table size");

	// remainder loop hands over to frame stepping after its last bit
	a_mod_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD && bit_cnt_q == '0) |=> (state_q == S_FETCH))
		else $error("remainder loop did not hand over");

	// a table read is always followed by its compare step
	a_fetch_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |=> (state_q == S_STEP))
		else $error("table read not followed by step");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the frame animation sequencer
module testbench;
	import fas_pkg::*;

	// first op code past the defined set
	localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_SET_DONE + 3'd1;

	// run shape
	localparam int RESET_CYCLES    = 12;
	localparam int ITEMS_PER_HALF  = 225;
	localparam int SETTLE_CYCLES   = 4;
	localparam int TAIL_CYCLES     = 200;
	localparam int QUIET_LIMIT     = 5000;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [TIME_W-1:0]  time_step;
		logic [TIME_W-1:0]  frame_time;
		logic [FRAME_W-1:0] frame_select;
		logic               restart;
		logic               flag_value;
	} request_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_index;
		logic               finished;
		logic               halted;
		logic               table_full;
	} status_t;

	logic clk = 1'b0;
	logic arst_n;

	fas_item_if   item_ch ();
	fas_result_if result_ch ();
	fas_cfg_if    cfg_ch ();

	frame_animation_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sequencer mirror: duration table, totals, position and flags
	logic [TIME_W-1:0]  dur_tab [MAX_FRAMES];
	logic [COUNT_W-1:0] n_frames   = '0;
	logic [ACC_W-1:0]   total_us   = '0;
	logic [ACC_W-1:0]   elapsed_us = '0;
	logic [COUNT_W-1:0] cur_frame  = '0;
	logic               paused     = 1'b0;
	logic               done       = 1'b0;
	logic               loop_mode  = 1'b0;

	status_t     expected_status [$];
	int unsigned fail_count     = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned stall_pct      = 0;
	int unsigned quiet_cycles   = 0;

	function automatic logic [COUNT_W-1:0] top_frame();
		return (n_frames == 0) ? '0 : n_frames - 1'b1;
	endfunction

	// wrap elapsed time by the total, then walk past every whole frame
	function automatic void advance_clock(logic [TIME_W-1:0] step);
		logic [SUM_W-1:0] sum;
		if (paused || done || n_frames == 0 || total_us == 0)
			return;
		sum = elapsed_us + step;
		elapsed_us = ACC_W'(sum % total_us);
		for (int g = 0; g < n_frames; g++) begin
			if (cur_frame >= n_frames)
				cur_frame = top_frame();
			if (elapsed_us < dur_tab[cur_frame])
				break;
			elapsed_us = elapsed_us - dur_tab[cur_frame];
			cur_frame = cur_frame + 1'b1;
			if (cur_frame >= n_frames) begin
				if (loop_mode) begin
					cur_frame = '0;
				end else begin
					cur_frame = top_frame();
					done = 1'b1;
					break;
				end
			end
		end
	endfunction

	// update the mirror for one request and give the status it reports
	function automatic status_t apply_request(request_t r);
		status_t s;
		s.table_full = 1'b0;
		case (r.op)
			OP_TICK: advance_clock(r.time_step);
			OP_ADD_FRAME: begin
				if (n_frames >= MAX_FRAMES) begin
					s.table_full = 1'b1;
				end else if (r.frame_time != 0) begin
					dur_tab[n_frames] = r.frame_time;
					n_frames = n_frames + 1'b1;
					total_us = total_us + r.frame_time;
				end
			end
			OP_SET_FRAME: begin
				cur_frame = (r.frame_select < top_frame()) ? COUNT_W'(r.frame_select) : top_frame();
				if (r.restart) begin
					paused = 1'b0;
					done = 1'b0;
					elapsed_us = '0;
				end
			end
			OP_SET_PAUSED: paused = r.flag_value;
			OP_SET_DONE: begin
				cur_frame = top_frame();
				done = r.flag_value;
			end
			default: ;
		endcase
		s.frame_index = cur_frame[FRAME_W-1:0];
		s.finished = done;
		s.halted = paused;
		return s;
	endfunction

	function automatic request_t compose(logic [OP_W-1:0] op, logic [TIME_W-1:0] amount = '0,
			logic [FRAME_W-1:0] sel = '0, logic restart = 1'b0, logic flag = 1'b0);
		request_t r;
		r.op = op;
		r.time_step = amount;
		r.frame_time = amount;
		r.frame_select = sel;
		r.restart = restart;
		r.flag_value = flag;
		return r;
	endfunction

	// mostly effective ticks over a slowly growing table, some noise
	function automatic request_t random_request();
		request_t    r;
		int unsigned pick;
		r.op = OP_TICK;
		r.time_step = $urandom;
		r.frame_time = $urandom;
		r.frame_select = FRAME_W'($urandom);
		r.restart = 1'($urandom);
		r.flag_value = 1'($urandom);
		pick = $urandom_range(99, 0);
		if (pick < 55) begin
			case ($urandom_range(3, 0))
				0, 1: r.time_step = $urandom_range(300, 0);
				2: r.time_step = $urandom_range(4000, 0);
				default: ;
			endcase
		end else if (pick < 63) begin
			r.op = OP_ADD_FRAME;
			pick = $urandom_range(19, 0);
			if (pick == 0)
				r.frame_time = '0;
			else if (pick > 1)
				r.frame_time = $urandom_range(200, 1);
		end else if (pick < 78) begin
			r.op = OP_SET_FRAME;
		end else if (pick < 86) begin
			r.op = OP_SET_PAUSED;
			r.flag_value = ($urandom_range(3, 0) == 0);
		end else if (pick < 94) begin
			r.op = OP_SET_DONE;
			r.flag_value = ($urandom_range(3, 0) == 0);
		end else begin
			r.op = OP_W'($urandom_range(2 ** OP_W - 1, OP_FIRST_UNUSED));
		end
		return r;
	endfunction

	// drive one request, with a random gap first, and log its expected status
	task automatic send_request(input request_t r);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.op           <= r.op;
		item_ch.time_step    <= r.time_step;
		item_ch.frame_time   <= r.frame_time;
		item_ch.frame_select <= r.frame_select;
		item_ch.restart      <= r.restart;
		item_ch.flag_value   <= r.flag_value;
		do
			@(posedge clk);
		while (!item_ch.ready);
		expected_status = {expected_status, apply_request(r)};
	endtask

	// hold requests off until every status has come back
	task automatic settle_idle();
		item_ch.valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_loop_enable(input logic value);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.loop_enable <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		loop_mode = value;
		cfg_ch.valid <= 1'b0;
	endtask

	// every op with no frames loaded, unknown ops and a zero-length frame
	task automatic test_empty_table();
		write_loop_enable(1'b0);
		send_request(compose(OP_TICK, 32'd100));
		send_request(compose(OP_SET_FRAME, '0, '1, 1'b0));
		send_request(compose(OP_SET_DONE, '0, '0, 1'b0, 1'b1));
		send_request(compose(OP_SET_DONE, '0, '0, 1'b0, 1'b0));
		send_request(compose(OP_SET_PAUSED, '0, '0, 1'b0, 1'b1));
		send_request(compose(OP_SET_PAUSED, '0, '0, 1'b0, 1'b0));
		for (int op = OP_FIRST_UNUSED; op < 2 ** OP_W; op++)
			send_request(compose(OP_W'(op), '1, '1, 1'b1, 1'b1));
		send_request(compose(OP_ADD_FRAME, '0));
	endtask

	// three frames, exact boundaries, clamping, running off the end, pause
	task automatic test_single_pass();
		send_request(compose(OP_ADD_FRAME, 32'd10));
		send_request(compose(OP_ADD_FRAME, 32'd20));
		send_request(compose(OP_ADD_FRAME, 32'd30));
		send_request(compose(OP_TICK, 32'd0));
		send_request(compose(OP_TICK, 32'd10));
		send_request(compose(OP_TICK, 32'd25));
		send_request(compose(OP_TICK, '1));
		send_request(compose(OP_SET_FRAME, '0, '1, 1'b1));
		send_request(compose(OP_TICK, 32'd30));
		send_request(compose(OP_TICK, 32'd5));
		send_request(compose(OP_SET_FRAME, '0, 6'd1, 1'b1));
		send_request(compose(OP_SET_PAUSED, '0, '0, 1'b0, 1'b1));
		send_request(compose(OP_TICK, 32'd15));
		send_request(compose(OP_SET_PAUSED, '0, '0, 1'b0, 1'b0));
	endtask

	// wrap around the last frame and a step of exactly the total
	task automatic test_looping();
		settle_idle();
		write_loop_enable(1'b1);
		send_request(compose(OP_SET_FRAME, '0, 6'd2, 1'b1));
		send_request(compose(OP_TICK, 32'd45));
		send_request(compose(OP_TICK, 32'd60));
		send_request(compose(OP_TICK, 32'd35));
	endtask

	// two halves, one per loop setting, under one idling pattern
	task automatic test_random_traffic(input int unsigned idle, input int unsigned stall);
		send_idle_pct = idle;
		stall_pct = stall;
		for (int half = 0; half < 2; half++) begin
			settle_idle();
			write_loop_enable(half == 1);
			repeat (ITEMS_PER_HALF) send_request(random_request());
		end
	endtask

	// fill the table, longest frame last, then refused adds
	task automatic test_table_full();
		send_idle_pct = 0;
		stall_pct = 0;
		while (n_frames < MAX_FRAMES)
			send_request(compose(OP_ADD_FRAME,
				(n_frames == MAX_FRAMES - 1) ? '1 : TIME_W'($urandom_range(200, 1))));
		send_request(compose(OP_ADD_FRAME, 32'd7));
		send_request(compose(OP_ADD_FRAME, '0));
		send_request(compose(OP_SET_FRAME, '0, '1, 1'b1));
		send_request(compose(OP_TICK, '1));
	endtask

	// result side back-pressure
	always @(posedge clk)
		result_ch.ready <= ($urandom_range(99, 0) >= stall_pct);

	// compare each returned status with the oldest expectation
	always @(posedge clk) begin : check_results
		status_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_status.size() == 0) begin
				$error("status returned with no request outstanding");
				fail_count++;
			end else begin
				want = expected_status.pop_front();
				if (result_ch.frame_index !== want.frame_index) begin
					$error("frame_index expected %0d got %0d", want.frame_index,
						result_ch.frame_index);
					fail_count++;
				end
				if (result_ch.finished !== want.finished) begin
					$error("finished expected %0b got %0b", want.finished, result_ch.finished);
					fail_count++;
				end
				if (result_ch.halted !== want.halted) begin
					$error("halted expected %0b got %0b", want.halted, result_ch.halted);
					fail_count++;
				end
				if (result_ch.table_full !== want.table_full) begin
					$error("table_full expected %0b got %0b", want.table_full,
						result_ch.table_full);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// test sequence
	initial begin
		arst_n               <= 1'b0;
		item_ch.valid        <= 1'b0;
		item_ch.op           <= OP_TICK;
		item_ch.time_step    <= '0;
		item_ch.frame_time   <= '0;
		item_ch.frame_select <= '0;
		item_ch.restart      <= 1'b0;
		item_ch.flag_value   <= 1'b0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.loop_enable   <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_single_pass();
		test_looping();
		test_random_traffic(0, 0);
		test_random_traffic(81, 0);
		test_random_traffic(0, 81);
		test_random_traffic(14, 14);
		test_table_full();
		settle_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
